// ----- hdl/hpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the histogram percentile tracker.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int NUM_BUCKETS_DEF     = 32;
  localparam int BUCKET_WIDTH_MS_DEF = 8;

  localparam int MARGIN_W = 16;
  localparam int COUNT_W  = 32;
  localparam int PCT_W    = 7;

  localparam logic [PCT_W-1:0] PERCENT_RESET = 7'd10;
  localparam int               PERCENT_SCALE = 100;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECORD = 2'd1,
    OP_REPORT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic stats_clr;  // clear statistics, rewind address
    logic sweep;      // write zero at address, advance
    logic cap;        // capture sample value
    logic rec_mul;    // reciprocal product, min/max/count update
    logic rec_rd;     // read bucket of the sample
    logic rec_wr;     // write incremented bucket count
    logic walk_init;  // start the percentile walk
    logic walk_rd;    // read bucket at address
    logic walk_mul;   // scale count by the percent scale
    logic walk_acc;   // accumulate, compare, advance
    logic out_load;   // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;  // address points at the last bucket
    logic hit;        // running sum reached the rank
    logic skip_walk;  // no samples or zero rank
  } sts_t;

endpackage
`default_nettype wire

// ----- hdl/histogram_percentile_tracker_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_percentile_tracker_core
// Margin histogram with running min/max/count and nearest-rank percentile.
// ----------------------------------------------------------------------------
// One item at a time. After reset, and after every clear item, a clearing
// pass zeroes the bucket memory one entry per cycle, and in_ready stays low
// until that pass ends. A record item runs a reciprocal multiply for the
// bucket index, then a read-modify-write of the bucket memory. A report
// item walks the cumulative bucket counts (memory read, scale by 100,
// accumulate and compare for each bucket) and stops at the bucket that
// reaches the rank, or at the last bucket; with no samples or percent 0 it
// skips the walk. The result waits in an output register, so new items are
// taken while it is pending; a second report stalls only until that
// register frees up. cfg_wr_data sets the percentile in whole percent.
// ----------------------------------------------------------------------------
module histogram_percentile_tracker_core #(
  parameter int NUM_BUCKETS     = hpt_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_WIDTH_MS = hpt_pkg::BUCKET_WIDTH_MS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_op,
  input  wire logic [hpt_pkg::MARGIN_W-1:0] in_margin_ms,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [hpt_pkg::MARGIN_W-1:0]      out_min_ms,
  output logic [hpt_pkg::MARGIN_W-1:0]      out_pct_ms,
  output logic [hpt_pkg::MARGIN_W-1:0]      out_max_ms,
  output logic [hpt_pkg::COUNT_W-1:0]       out_sample_count,
  input  wire logic                         cfg_wr_en,
  input  wire logic [hpt_pkg::PCT_W-1:0]    cfg_wr_data
);

  hpt_pkg::cmd_t cmd;
  hpt_pkg::sts_t sts;

  hpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hpt_datapath #(
    .NUM_BUCKETS     (NUM_BUCKETS),
    .BUCKET_WIDTH_MS (BUCKET_WIDTH_MS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_margin_ms     (in_margin_ms),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_min_ms       (out_min_ms),
    .out_pct_ms       (out_pct_ms),
    .out_max_ms       (out_max_ms),
    .out_sample_count (out_sample_count)
  );

`ifndef SYNTHESIS
  // a clear item starts the clearing pass, which blocks input
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == hpt_pkg::OP_CLEAR)) |=> !in_ready)
    else $error("input taken during clearing pass");

  // a record item blocks input while it updates the bucket memory
  a_record_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_op == hpt_pkg::OP_RECORD)) |=> !in_ready)
    else $error("input taken during bucket update");

  // an empty histogram reports all zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_sample_count == '0)) |->
      ((out_min_ms == '0) && (out_pct_ms == '0) && (out_max_ms == '0)))
    else $error("nonzero statistics without samples");

  // with samples, min never exceeds max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_sample_count != '0)) |-> (out_min_ms <= out_max_ms))
    else $error("reported min above max");
`endif

endmodule
`default_nettype wire

// ----- hdl/hpt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_ctrl
// Sequencer for clearing sweep, sample record and percentile walk.
// ----------------------------------------------------------------------------
module hpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire hpt_pkg::sts_t sts,
  output hpt_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_REC_MUL,
    S_REC_RD,
    S_REC_WR,
    S_RPT_RD,
    S_RPT_MUL,
    S_RPT_ACC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign take      = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.addr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (take) begin
          cmd.cap = 1'b1;
          unique case (in_op)
            hpt_pkg::OP_CLEAR: begin
              cmd.stats_clr = 1'b1;
              state_nxt     = S_SWEEP;
            end
            hpt_pkg::OP_RECORD: begin
              state_nxt = S_REC_MUL;
            end
            hpt_pkg::OP_REPORT: begin
              cmd.walk_init = 1'b1;
              state_nxt     = sts.skip_walk ? S_DONE : S_RPT_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_REC_MUL: begin
        cmd.rec_mul = 1'b1;
        state_nxt   = S_REC_RD;
      end
      S_REC_RD: begin
        cmd.rec_rd = 1'b1;
        state_nxt  = S_REC_WR;
      end
      S_REC_WR: begin
        cmd.rec_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RPT_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_RPT_MUL;
      end
      S_RPT_MUL: begin
        cmd.walk_mul = 1'b1;
        state_nxt    = S_RPT_ACC;
      end
      S_RPT_ACC: begin
        cmd.walk_acc = 1'b1;
        if (sts.hit || sts.addr_last) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RPT_RD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hpt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_datapath
// Bucket memory, running statistics, rank walk and result register.
// ----------------------------------------------------------------------------
module hpt_datapath #(
  parameter int NUM_BUCKETS     = hpt_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_WIDTH_MS = hpt_pkg::BUCKET_WIDTH_MS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire hpt_pkg::cmd_t                  cmd,
  output hpt_pkg::sts_t                       sts,
  input  wire logic [hpt_pkg::MARGIN_W-1:0]   in_margin_ms,
  input  wire logic                           cfg_wr_en,
  input  wire logic [hpt_pkg::PCT_W-1:0]      cfg_wr_data,
  output logic [hpt_pkg::MARGIN_W-1:0]        out_min_ms,
  output logic [hpt_pkg::MARGIN_W-1:0]        out_pct_ms,
  output logic [hpt_pkg::MARGIN_W-1:0]        out_max_ms,
  output logic [hpt_pkg::COUNT_W-1:0]         out_sample_count
);

  localparam int MW    = hpt_pkg::MARGIN_W;
  localparam int CW    = hpt_pkg::COUNT_W;
  localparam int PW    = hpt_pkg::PCT_W;
  localparam int AW    = $clog2(NUM_BUCKETS);
  // rank product seen * percent, and running sum of count * 100
  localparam int XW    = CW + PW;
  localparam int ACC_W = XW + AW;
  // exact quotient for 16-bit numerators: q = (n * RECIP) >> SH
  localparam int SH    = MW + $clog2(BUCKET_WIDTH_MS);
  localparam int RW    = SH + 1;
  localparam int RECIP = ((2 ** SH) + BUCKET_WIDTH_MS - 1) / BUCKET_WIDTH_MS;
  localparam int PRW   = MW + RW;

  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
  localparam logic [MW-1:0] NB_C    = MW'(NUM_BUCKETS);
  localparam logic [AW-1:0] LAST_C  = AW'(NUM_BUCKETS - 1);
  localparam logic [MW-1:0] BW_C    = MW'(BUCKET_WIDTH_MS);
  localparam logic [PW:0]   SCALE_C = (PW + 1)'(hpt_pkg::PERCENT_SCALE);

  logic [CW-1:0]    mem [NUM_BUCKETS];
  logic [CW-1:0]    rdata_r;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [CW-1:0]    mem_wdata;

  logic [AW-1:0]    addr_r;
  logic [MW-1:0]    margin_r;
  logic [PRW-1:0]   prod_r;
  logic [MW-1:0]    quot;
  logic [AW-1:0]    rec_idx;

  logic [CW-1:0]    seen_r;
  logic [MW-1:0]    low_r;
  logic [MW-1:0]    high_r;
  logic [PW-1:0]    pct_r;

  logic [XW-1:0]    x_r;
  logic [XW-1:0]    c100_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [MW-1:0]    edge_r;
  logic [MW-1:0]    walk_edge;

  // bucket index from the reciprocal product, clamped to the last bucket
  assign quot    = prod_r[SH +: MW];
  assign rec_idx = (quot >= NB_C) ? LAST_C : quot[AW-1:0];

  assign rd_addr   = cmd.rec_rd ? rec_idx : addr_r;
  assign mem_we    = cmd.sweep || cmd.rec_wr;
  assign mem_wdata = cmd.sweep ? '0 :
                     ((rdata_r == '1) ? rdata_r : rdata_r + CW'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr_r] <= mem_wdata;
    end
    if (cmd.rec_rd || cmd.walk_rd) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign acc_nxt   = acc_r + ACC_W'(c100_r);
  assign walk_edge = MW'(MW'(addr_r) * BW_C);

  assign sts.addr_last = (addr_r == LAST_C);
  assign sts.hit       = (acc_nxt >= ACC_W'(x_r));
  assign sts.skip_walk = (seen_r == '0) || (pct_r == '0);

  // control and statistics state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      seen_r <= '0;
      low_r  <= '1;
      high_r <= '0;
      pct_r  <= hpt_pkg::PERCENT_RESET;
    end else begin
      if (cfg_wr_en) begin
        pct_r <= cfg_wr_data;
      end
      if (cmd.stats_clr) begin
        seen_r <= '0;
        low_r  <= '1;
        high_r <= '0;
      end
      if (cmd.rec_mul) begin
        if (seen_r != '1) begin
          seen_r <= seen_r + CW'(1);
        end
        if (margin_r < low_r) begin
          low_r <= margin_r;
        end
        if (margin_r > high_r) begin
          high_r <= margin_r;
        end
      end
      priority if (cmd.stats_clr || cmd.walk_init) begin
        addr_r <= '0;
      end else if (cmd.sweep) begin
        if (addr_r != LAST_C) begin
          addr_r <= addr_r + AW'(1);
        end
      end else if (cmd.rec_rd) begin
        addr_r <= rec_idx;
      end else if (cmd.walk_acc) begin
        if (!sts.hit && (addr_r != LAST_C)) begin
          addr_r <= addr_r + AW'(1);
        end
      end else begin
        addr_r <= addr_r;
      end
    end
  end

  // payload pipeline and result register
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      margin_r <= in_margin_ms;
    end
    if (cmd.rec_mul) begin
      prod_r <= PRW'(margin_r) * PRW'(RECIP_C);
    end
    if (cmd.walk_init) begin
      x_r   <= XW'(seen_r) * XW'(pct_r);
      acc_r <= '0;
    end
    if (cmd.walk_mul) begin
      c100_r <= XW'(rdata_r) * XW'(SCALE_C);
    end
    if (cmd.walk_acc) begin
      acc_r  <= acc_nxt;
      // past the last bucket without reaching the rank: fall back to max
      edge_r <= sts.hit ? walk_edge : high_r;
    end
    if (cmd.out_load) begin
      out_sample_count <= seen_r;
      out_max_ms       <= high_r;
      if (seen_r == '0) begin
        out_min_ms <= '0;
        out_pct_ms <= '0;
      end else begin
        out_min_ms <= low_r;
        out_pct_ms <= (pct_r == '0) ? high_r : edge_r;
      end
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/hpt_report_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpt_report_checker
// Watches the item, result and register ports of the histogram percentile
// tracker, keeps its own copy of the histogram, min/max and sample count,
// predicts every report and compares each result field by field.
// ----------------------------------------------------------------------------
module hpt_report_checker
  import hpt_pkg::*;
#(
  parameter int NUM_BUCKETS     = NUM_BUCKETS_DEF,
  parameter int BUCKET_WIDTH_MS = BUCKET_WIDTH_MS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [MARGIN_W-1:0] in_margin_ms,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [MARGIN_W-1:0] out_min_ms,
  input  logic [MARGIN_W-1:0] out_pct_ms,
  input  logic [MARGIN_W-1:0] out_max_ms,
  input  logic [COUNT_W-1:0]  out_sample_count,
  input  logic                cfg_wr_en,
  input  logic [PCT_W-1:0]    cfg_wr_data,
  output int                  fail_count,
  output int                  pending_reports
);

  typedef struct packed {
    logic [MARGIN_W-1:0] min_ms;
    logic [MARGIN_W-1:0] pct_ms;
    logic [MARGIN_W-1:0] max_ms;
    logic [COUNT_W-1:0]  sample_count;
  } stats_report_t;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic [COUNT_W-1:0]  bucket_tally [NUM_BUCKETS];
  logic [COUNT_W-1:0]  sample_total;
  logic [MARGIN_W-1:0] floor_ms;
  logic [MARGIN_W-1:0] peak_ms;
  logic [PCT_W-1:0]    pct_setting;
  stats_report_t       expected_reports [$];

  function automatic void clear_histogram();
    for (int b = 0; b < NUM_BUCKETS; b++) bucket_tally[b] = '0;
    sample_total = '0;
    floor_ms     = '1;
    peak_ms      = '0;
  endfunction

  function automatic void record_margin(logic [MARGIN_W-1:0] margin);
    int idx;
    idx = int'(margin) / BUCKET_WIDTH_MS;
    if (idx >= NUM_BUCKETS) idx = NUM_BUCKETS - 1;
    if (bucket_tally[idx] != COUNT_MAX) bucket_tally[idx] = bucket_tally[idx] + 1'b1;
    if (sample_total != COUNT_MAX) sample_total = sample_total + 1'b1;
    if (margin < floor_ms) floor_ms = margin;
    if (margin > peak_ms) peak_ms = margin;
  endfunction

  // nearest rank rounded up, reported as the lower edge of the bucket
  function automatic logic [MARGIN_W-1:0] percentile_edge_ms();
    logic [63:0] rank;
    logic [63:0] running;
    if (sample_total == '0) return '0;
    rank = (64'(sample_total) * 64'(pct_setting) + 64'(PERCENT_SCALE - 1))
           / 64'(PERCENT_SCALE);
    if (rank == 64'd0) return peak_ms;
    running = '0;
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      running = running + 64'(bucket_tally[b]);
      if (running >= rank) return MARGIN_W'(b * BUCKET_WIDTH_MS);
    end
    return peak_ms;
  endfunction

  function automatic stats_report_t predict_report();
    stats_report_t r;
    r.min_ms       = (sample_total == '0) ? '0 : floor_ms;
    r.pct_ms       = percentile_edge_ms();
    r.max_ms       = peak_ms;
    r.sample_count = sample_total;
    return r;
  endfunction

  always @(posedge clk) begin
    stats_report_t want;
    if (!rst_n) begin
      clear_histogram();
      pct_setting = PERCENT_RESET;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("%0t: result with no report pending: min %0d pct %0d max %0d count %0d",
                     $time, out_min_ms, out_pct_ms, out_max_ms, out_sample_count);
        end else begin
          want = expected_reports.pop_front();
          if (out_min_ms !== want.min_ms || out_pct_ms !== want.pct_ms ||
              out_max_ms !== want.max_ms || out_sample_count !== want.sample_count) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("%0t: report mismatch: expected min %0d pct %0d max %0d count %0d",
                       $time, want.min_ms, want.pct_ms, want.max_ms, want.sample_count);
              $display("%0t: report mismatch: got      min %0d pct %0d max %0d count %0d",
                       $time, out_min_ms, out_pct_ms, out_max_ms, out_sample_count);
            end
          end
        end
      end
      if (cfg_wr_en) pct_setting = cfg_wr_data;
      if (in_valid && in_ready) begin
        case (op_t'(in_op))
          OP_CLEAR:  clear_histogram();
          OP_RECORD: record_margin(in_margin_ms);
          OP_REPORT: expected_reports.push_back(predict_report());
          default: ;
        endcase
      end
    end
    pending_reports = expected_reports.size();
  end

endmodule

// ----- tb/sv/tb_histogram_percentile_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_percentile_tracker_core
// Drives clear, record, report and unused items into the tracker under
// several idle and stall patterns and percentile settings; the checker
// beside the block predicts each report and counts mismatches.
// ----------------------------------------------------------------------------
module tb_histogram_percentile_tracker_core;
  import hpt_pkg::*;

  localparam int SETTLE_CYCLES = 120;   // longest report walk plus margin
  localparam int STALL_LIMIT   = 4000;  // cycles without any item moving

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  op_t                 in_op        = OP_NONE;
  logic [MARGIN_W-1:0] in_margin_ms = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [MARGIN_W-1:0] out_min_ms;
  logic [MARGIN_W-1:0] out_pct_ms;
  logic [MARGIN_W-1:0] out_max_ms;
  logic [COUNT_W-1:0]  out_sample_count;
  logic                cfg_wr_en    = 1'b0;
  logic [PCT_W-1:0]    cfg_wr_data  = '0;

  int fail_count;
  int pending_reports;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  histogram_percentile_tracker_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_margin_ms     (in_margin_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_min_ms       (out_min_ms),
    .out_pct_ms       (out_pct_ms),
    .out_max_ms       (out_max_ms),
    .out_sample_count (out_sample_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  hpt_report_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_margin_ms     (in_margin_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_min_ms       (out_min_ms),
    .out_pct_ms       (out_pct_ms),
    .out_max_ms       (out_max_ms),
    .out_sample_count (out_sample_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .pending_reports  (pending_reports)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic push_item(op_t op, logic [MARGIN_W-1:0] margin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_margin_ms <= margin;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold the sender until every report has come back and the block is idle
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_reports != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_percent(logic [PCT_W-1:0] pct);
    quiesce();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pct;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [MARGIN_W-1:0] pick_margin();
    case ($urandom_range(3))
      0:       return MARGIN_W'($urandom_range(63));
      1:       return MARGIN_W'($urandom_range(255));
      2:       return MARGIN_W'($urandom);
      default: return MARGIN_W'($urandom_range(300, 200));
    endcase
  endfunction

  function automatic logic [PCT_W-1:0] pick_percent();
    case ($urandom_range(5))
      0:       return '0;
      1:       return PCT_W'(PERCENT_SCALE);
      2:       return PCT_W'($urandom_range(127, 101));
      default: return PCT_W'($urandom_range(99, 1));
    endcase
  endfunction

  // mostly records with an occasional report; clears and unused ops are rare
  task automatic run_random(int n);
    int roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 2)       push_item(OP_CLEAR, MARGIN_W'($urandom));
      else if (roll < 5)  push_item(OP_NONE, MARGIN_W'($urandom));
      else if (roll < 18) push_item(OP_REPORT, MARGIN_W'($urandom));
      else                push_item(OP_RECORD, pick_margin());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty stats, bucket clamp, unused op, clear, percent extremes
    push_item(OP_REPORT, 16'h0000);
    push_item(OP_NONE, 16'hFFFF);
    push_item(OP_REPORT, 16'hFFFF);
    push_item(OP_RECORD, 16'h0000);
    push_item(OP_RECORD, 16'hFFFF);
    push_item(OP_RECORD, 16'd255);
    push_item(OP_RECORD, 16'd256);
    push_item(OP_RECORD, 16'd7);
    push_item(OP_RECORD, 16'd8);
    push_item(OP_RECORD, 16'h5555);
    push_item(OP_RECORD, 16'hAAAA);
    push_item(OP_REPORT, 16'h0000);
    push_item(OP_CLEAR, 16'hFFFF);
    push_item(OP_REPORT, 16'h0000);
    push_item(OP_RECORD, 16'd100);
    push_item(OP_RECORD, 16'd3);
    push_item(OP_REPORT, 16'h0000);
    set_percent('0);
    push_item(OP_REPORT, 16'h0000);
    set_percent(PCT_W'(PERCENT_SCALE));
    push_item(OP_REPORT, 16'h0000);
    set_percent('1);
    push_item(OP_REPORT, 16'h0000);
    set_percent(PCT_W'(1));
    push_item(OP_REPORT, 16'h0000);
    set_percent(PCT_W'(99));
    push_item(OP_REPORT, 16'h0000);

    for (int phase = 0; phase < 4; phase++) begin
      set_percent(pick_percent());
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      run_random(80);
      quiesce();
      run_random(80);
    end

    in_valid <= 1'b0;
    while (pending_reports != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
